[rtl/glyph_blit_clipped_top_defines.svh]
`ifndef GLYPH_BLIT_CLIPPED_TOP_DEFINES_SVH
`define GLYPH_BLIT_CLIPPED_TOP_DEFINES_SVH

// same-cycle implication
`define GBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/gbc_pkg.sv]
package gbc_pkg;

  localparam int GLYPH_COUNT     = 128;
  localparam int MAX_CELL_HEIGHT = 16;
  localparam int MAX_CELL_WIDTH  = 16;
  localparam int BITMAP_DEPTH    = 4096;
  localparam int BITMAP_AW       = 12;
  localparam int GIDX_W          = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  localparam int OPCODE_W = 2;
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_DRAW        = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_BITMAP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOAD_WIDTH  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_FG_COLOUR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BG_COLOUR   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FB_WIDTH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FB_HEIGHT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_CHAR  = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_YMUL,
    S_COLS,
    S_ROW
  } state_t;

endpackage

[rtl/gbc_if.sv]
interface gbc_item_if;
  logic                          valid;
  logic                          ready;
  logic [gbc_pkg::OPCODE_W-1:0]  opcode;
  logic [7:0]                    char_code;
  logic signed [10:0]            pos_x;
  logic signed [10:0]            pos_y;
  logic [11:0]                   table_index;
  logic [7:0]                    table_data;

  modport source (output valid, opcode, char_code, pos_x, pos_y, table_index, table_data,
                  input ready);
  modport sink (input valid, opcode, char_code, pos_x, pos_y, table_index, table_data,
                output ready);
endinterface

interface gbc_result_if;
  logic        valid;
  logic        ready;
  logic [19:0] row_address;
  logic [15:0] set_mask;
  logic [15:0] write_mask;
  logic [15:0] fg_word;
  logic [15:0] bg_word;
  logic [4:0]  advance;
  logic        last_row;

  modport source (output valid, row_address, set_mask, write_mask, fg_word, bg_word,
                  advance, last_row, input ready);
  modport sink (input valid, row_address, set_mask, write_mask, fg_word, bg_word,
                advance, last_row, output ready);
endinterface

interface gbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbc_pkg::REG_IDX_W-1:0]  index;
  logic [gbc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/glyph_blit_clipped_top.sv]
// Glyph blitter: loads (bitmap byte, width entry) are taken while idle. A draw goes
// through the setup states (S_BASE, S_YMUL, S_COLS), then gives one result per glyph
// row (cell_height rows, 1 to 16) at one row a cycle while results are taken. The setup is
// paced by the single shared multiplier, used for the glyph base address and then the
// first row's pixel offset; each row then costs one read of the bitmap's two read ports.
// The block takes no new request until the last row result has been registered.
// Bitmap and width entries must be loaded before a draw reads them.
`include "glyph_blit_clipped_top_defines.svh"

module glyph_blit_clipped_top (
  input  logic               clk,
  input  logic               rst,
  gbc_item_if.sink           items,
  gbc_result_if.source       results,
  gbc_cfg_if.sink            cfg
);

  // configuration
  logic [15:0] fg_colour;
  logic [15:0] bg_colour;
  logic [2:0]  mode;
  logic [9:0]  fb_width;
  logic [9:0]  fb_height;
  logic [4:0]  cell_width;
  logic [4:0]  cell_height;
  logic [7:0]  first_char;

  // storage
  logic [7:0] bitmap [gbc_pkg::BITMAP_DEPTH];
  logic [4:0] wtab [gbc_pkg::GLYPH_COUNT];
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [4:0] wtab_rd;

  gbc_pkg::state_t state, state_next;

  // draw context
  logic               glyph_ok;
  logic [7:0]         glyph_idx;
  logic signed [10:0] px;
  logic signed [10:0] py;
  logic signed [21:0] mul_q;
  logic [11:0]        row_ptr;
  logic signed [21:0] ymul;
  logic signed [11:0] y;
  logic [3:0]         row;
  logic [4:0]         adv;
  logic [15:0]        col_mask;
  logic [3:0]         col_shift;
  logic               col_any;
  logic [9:0]         col_start;

  // output register
  logic        res_valid;
  logic [19:0] res_row_address;
  logic [15:0] res_set_mask;
  logic [15:0] res_write_mask;
  logic [15:0] res_fg_word;
  logic [15:0] res_bg_word;
  logic [4:0]  res_advance;
  logic        res_last;

  // control
  logic               in_acc;
  logic               step;
  logic               rd_en;
  logic [11:0]        rd_addr;
  logic signed [10:0] mul_a;
  logic signed [10:0] mul_b;

  // derived
  logic [4:0]         cw;
  logic [4:0]         ch;
  logic               stride2;
  logic               last;
  logic [8:0]         code_diff;
  logic [4:0]         wt_sat;
  logic [4:0]         width_sel;
  logic signed [11:0] lim;
  logic [11:0]        neg_px;
  logic [4:0]         xs;
  logic [4:0]         xe;
  logic [15:0]        bm16;
  logic [15:0]        row_set;
  logic               row_vis;

  function automatic logic [15:0] low_mask(input logic [4:0] n);
    logic [16:0] m;
    m = (17'd1 << n) - 17'd1;
    return m[15:0];
  endfunction

  assign in_acc = items.valid && items.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    cw = cell_width;
    if (cell_width == 5'd0) cw = 5'd1;
    else if (cell_width > 5'(gbc_pkg::MAX_CELL_WIDTH)) cw = 5'(gbc_pkg::MAX_CELL_WIDTH);
    ch = cell_height;
    if (cell_height == 5'd0) ch = 5'd1;
    else if (cell_height > 5'(gbc_pkg::MAX_CELL_HEIGHT)) ch = 5'(gbc_pkg::MAX_CELL_HEIGHT);
  end

  assign stride2   = (cw > 5'd8);
  assign last      = (({1'b0, row} + 5'd1) == ch);
  assign code_diff = {1'b0, items.char_code} - {1'b0, first_char};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_colour   <= 16'hffff;
      bg_colour   <= 16'd0;
      mode        <= 3'd0;
      fb_width    <= 10'd320;
      fb_height   <= 10'd240;
      cell_width  <= 5'd8;
      cell_height <= 5'd8;
      first_char  <= 8'd32;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        gbc_pkg::REG_FG_COLOUR:   fg_colour   <= cfg.data;
        gbc_pkg::REG_BG_COLOUR:   bg_colour   <= cfg.data;
        gbc_pkg::REG_MODE:        mode        <= cfg.data[2:0];
        gbc_pkg::REG_FB_WIDTH:    fb_width    <= cfg.data[9:0];
        gbc_pkg::REG_FB_HEIGHT:   fb_height   <= cfg.data[9:0];
        gbc_pkg::REG_CELL_WIDTH:  cell_width  <= cfg.data[4:0];
        gbc_pkg::REG_CELL_HEIGHT: cell_height <= cfg.data[4:0];
        gbc_pkg::REG_FIRST_CHAR:  first_char  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // bitmap memory: one write port, two read ports (row byte and the one after it)
  always_ff @(posedge clk) begin
    if (in_acc && items.opcode == gbc_pkg::OP_LOAD_BITMAP) begin
      bitmap[items.table_index] <= items.table_data;
    end
    if (rd_en) begin
      byte0 <= bitmap[rd_addr];
      byte1 <= bitmap[rd_addr + 12'd1];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && items.opcode == gbc_pkg::OP_LOAD_WIDTH &&
        items.table_index < 12'(gbc_pkg::GLYPH_COUNT)) begin
      wtab[items.table_index[gbc_pkg::GIDX_W-1:0]] <= items.table_data[4:0];
    end
    wtab_rd <= wtab[glyph_idx[gbc_pkg::GIDX_W-1:0]];
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      gbc_pkg::S_IDLE: if (in_acc && items.opcode == gbc_pkg::OP_DRAW) state_next = gbc_pkg::S_BASE;
      gbc_pkg::S_BASE: state_next = gbc_pkg::S_YMUL;
      gbc_pkg::S_YMUL: state_next = gbc_pkg::S_COLS;
      gbc_pkg::S_COLS: state_next = gbc_pkg::S_ROW;
      gbc_pkg::S_ROW:  if (step && last) state_next = gbc_pkg::S_IDLE;
      default:         state_next = gbc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    items.ready = 1'b0;
    step        = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = row_ptr + (stride2 ? 12'd2 : 12'd1);
    mul_a       = {6'd0, ch};
    mul_b       = {3'd0, glyph_idx};
    case (state)
      gbc_pkg::S_IDLE: items.ready = 1'b1;
      gbc_pkg::S_BASE: ;
      gbc_pkg::S_YMUL: begin
        mul_a = py;
        mul_b = {1'b0, fb_width};
      end
      gbc_pkg::S_COLS: begin
        rd_en   = 1'b1;
        rd_addr = row_ptr;
      end
      gbc_pkg::S_ROW: begin
        step  = !res_valid || results.ready;
        rd_en = step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gbc_pkg::S_IDLE;
    else     state <= state_next;
  end

  // shared multiplier: glyph row base, then first row's pixel offset
  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  // column window
  always_comb begin
    wt_sat    = (wtab_rd > 5'(gbc_pkg::MAX_CELL_WIDTH)) ? 5'(gbc_pkg::MAX_CELL_WIDTH) : wtab_rd;
    width_sel = !glyph_ok ? 5'd0 : (mode[2] ? wt_sat : cw);
    lim       = $signed({2'b00, fb_width}) - $signed({px[10], px});
    neg_px    = px[10] ? 12'(-$signed({px[10], px})) : 12'd0;
    xs        = (neg_px > 12'd16) ? 5'd16 : neg_px[4:0];
    if (lim[11])                         xe = 5'd0;
    else if (lim < $signed({7'd0, width_sel})) xe = lim[4:0];
    else                                 xe = width_sel;
  end

  always_ff @(posedge clk) begin
    case (state)
      gbc_pkg::S_IDLE: if (in_acc) begin
        glyph_ok  <= !code_diff[8] && (code_diff < 9'(gbc_pkg::GLYPH_COUNT));
        glyph_idx <= (!code_diff[8] && (code_diff < 9'(gbc_pkg::GLYPH_COUNT))) ?
                     code_diff[7:0] : 8'd0;
        px        <= items.pos_x;
        py        <= items.pos_y;
      end
      gbc_pkg::S_YMUL: begin
        row_ptr <= stride2 ? {mul_q[10:0], 1'b0} : mul_q[11:0];
      end
      gbc_pkg::S_COLS: begin
        ymul      <= mul_q;
        y         <= {py[10], py};
        row       <= 4'd0;
        adv       <= width_sel;
        col_any   <= xe > xs;
        col_mask  <= low_mask(xe) & ~low_mask(xs);
        col_shift <= xs[3:0];
        col_start <= px[10] ? 10'd0 : px[9:0];
      end
      gbc_pkg::S_ROW: if (step) begin
        row_ptr <= rd_addr;
        ymul    <= ymul + $signed({12'd0, fb_width});
        y       <= y + 12'sd1;
        row     <= row + 4'd1;
      end
      default: ;
    endcase
  end

  // row result
  assign bm16    = {stride2 ? byte1 : 8'd0, byte0};
  assign row_vis = glyph_ok && col_any && !y[11] && (y[10:0] < {1'b0, fb_height});
  assign row_set = (bm16 & col_mask) >> col_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_row_address <= row_vis ? (ymul[19:0] + {10'd0, col_start}) : 20'd0;
      res_set_mask    <= row_vis ? row_set : 16'd0;
      res_write_mask  <= !row_vis ? 16'd0 : (mode[0] ? (col_mask >> col_shift) : row_set);
      res_fg_word     <= mode[1] ? {fg_colour[7:0], fg_colour[15:8]} : fg_colour;
      res_bg_word     <= mode[1] ? {bg_colour[7:0], bg_colour[15:8]} : bg_colour;
      res_advance     <= adv;
      res_last        <= last;
    end
  end

  assign results.valid       = res_valid;
  assign results.row_address = res_row_address;
  assign results.set_mask    = res_set_mask;
  assign results.write_mask  = res_write_mask;
  assign results.fg_word     = res_fg_word;
  assign results.bg_word     = res_bg_word;
  assign results.advance     = res_advance;
  assign results.last_row    = res_last;

  `GBC_ASSERT_NOW(a_row_in_range, clk, rst, state == gbc_pkg::S_ROW, {1'b0, row} < ch, "row counter past glyph height")
  `GBC_ASSERT_NEXT(a_last_row_ends, clk, rst, step && last, state == gbc_pkg::S_IDLE && res_valid && res_last, "draw did not end on its last row")
  `GBC_ASSERT_NEXT(a_draw_starts, clk, rst, in_acc && items.opcode == gbc_pkg::OP_DRAW, state == gbc_pkg::S_BASE, "draw request did not start setup")
  `GBC_ASSERT_NOW(a_empty_row_clear, clk, rst, res_valid && !res_advance[4] && res_advance[3:0] == 4'd0, res_set_mask == 16'd0 && res_row_address == 20'd0, "zero-width glyph gave pixels")

endmodule

[tb/gbc_blit_checker.sv]
`timescale 1ns / 100ps

module gbc_blit_checker
  import gbc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  gbc_item_if   items,
  gbc_result_if results,
  gbc_cfg_if    cfg,
  output int    fail_count,
  output int    rows_pending
);

  localparam int MODE_FILL_BIT        = 0;
  localparam int MODE_SWAP_BIT        = 1;
  localparam int MODE_WIDTH_TABLE_BIT = 2;

  typedef struct packed {
    logic [19:0] row_address;
    logic [15:0] set_mask;
    logic [15:0] write_mask;
    logic [15:0] fg_word;
    logic [15:0] bg_word;
    logic [4:0]  advance;
    logic        last_row;
  } glyph_row_t;

  glyph_row_t  expected_rows [$];
  glyph_row_t  want;
  logic [7:0]  bitmap_mem [BITMAP_DEPTH];
  logic [4:0]  width_mem [GLYPH_COUNT];
  logic [15:0] fg_colour, bg_colour;
  logic [2:0]  mode;
  logic [9:0]  fb_width, fb_height;
  logic [4:0]  cell_width, cell_height;
  logic [7:0]  first_char;
  int          mismatch_count = 0;

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // One expected row per glyph row, clipped against the framebuffer.
  task automatic rasterise_glyph(input logic [7:0] code, input logic signed [10:0] pos_x,
                                 input logic signed [10:0] pos_y);
    int          cw, ch, stride, gi, glyph_w, base, px, py, y, xstart, xend, byte_idx;
    bit          in_font, pixel_on;
    logic [15:0] fg_w, bg_w;
    glyph_row_t  row;
    cw      = clamp_int(int'(cell_width), 1, MAX_CELL_WIDTH);
    ch      = clamp_int(int'(cell_height), 1, MAX_CELL_HEIGHT);
    stride  = (cw + 7) / 8;
    in_font = (code >= first_char) && (int'(code) - int'(first_char) < GLYPH_COUNT);
    gi      = in_font ? int'(code) - int'(first_char) : 0;
    glyph_w = 0;
    if (in_font) begin
      glyph_w = mode[MODE_WIDTH_TABLE_BIT] ? int'(width_mem[gi]) : cw;
      if (glyph_w > MAX_CELL_WIDTH) glyph_w = MAX_CELL_WIDTH;
    end
    fg_w   = mode[MODE_SWAP_BIT] ? {fg_colour[7:0], fg_colour[15:8]} : fg_colour;
    bg_w   = mode[MODE_SWAP_BIT] ? {bg_colour[7:0], bg_colour[15:8]} : bg_colour;
    base   = stride * ch * gi;
    px     = int'(pos_x);
    py     = int'(pos_y);
    xstart = (px < 0) ? -px : 0;
    xend   = glyph_w;
    if (px + xend > int'(fb_width)) xend = int'(fb_width) - px;
    for (int r = 0; r < ch; r++) begin
      row = '0;
      y   = py + r;
      if (in_font && y >= 0 && y < int'(fb_height) && xend > xstart) begin
        row.row_address = 20'(y * int'(fb_width) + px + xstart);
        for (int x = xstart; x < xend; x++) begin
          byte_idx = x / 8;
          // columns past the stored stride are blank
          pixel_on = (byte_idx < stride) &&
                     bitmap_mem[(base + r * stride + byte_idx) % BITMAP_DEPTH][x % 8];
          if (pixel_on) begin
            row.set_mask[x - xstart]   = 1'b1;
            row.write_mask[x - xstart] = 1'b1;
          end else if (mode[MODE_FILL_BIT]) begin
            row.write_mask[x - xstart] = 1'b1;
          end
        end
      end
      row.fg_word  = fg_w;
      row.bg_word  = bg_w;
      row.advance  = 5'(glyph_w);
      row.last_row = (r == ch - 1);
      expected_rows.push_back(row);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fg_colour   = 16'hFFFF;
      bg_colour   = 16'h0000;
      mode        = 3'b000;
      fb_width    = 10'd320;
      fb_height   = 10'd240;
      cell_width  = 5'd8;
      cell_height = 5'd8;
      first_char  = 8'd32;
      expected_rows.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (expected_rows.size() == 0) begin
          $error("row result with no request outstanding: row_address 0x%0h",
                 results.row_address);
          mismatch_count++;
        end else begin
          want = expected_rows.pop_front();
          check_field("row_address", want.row_address, results.row_address);
          check_field("set_mask", want.set_mask, results.set_mask);
          check_field("write_mask", want.write_mask, results.write_mask);
          check_field("fg_word", want.fg_word, results.fg_word);
          check_field("bg_word", want.bg_word, results.bg_word);
          check_field("advance", want.advance, results.advance);
          check_field("last_row", want.last_row, results.last_row);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FG_COLOUR:   fg_colour   = cfg.data;
          REG_BG_COLOUR:   bg_colour   = cfg.data;
          REG_MODE:        mode        = cfg.data[2:0];
          REG_FB_WIDTH:    fb_width    = cfg.data[9:0];
          REG_FB_HEIGHT:   fb_height   = cfg.data[9:0];
          REG_CELL_WIDTH:  cell_width  = cfg.data[4:0];
          REG_CELL_HEIGHT: cell_height = cfg.data[4:0];
          REG_FIRST_CHAR:  first_char  = cfg.data[7:0];
          default: ;
        endcase
      end
      if (items.valid && items.ready) begin
        case (items.opcode)
          OP_DRAW:        rasterise_glyph(items.char_code, items.pos_x, items.pos_y);
          OP_LOAD_BITMAP: bitmap_mem[items.table_index] = items.table_data;
          OP_LOAD_WIDTH: begin
            if (items.table_index < GLYPH_COUNT)
              width_mem[items.table_index[GIDX_W-1:0]] = items.table_data[4:0];
          end
          default: ;
        endcase
      end
    end
    rows_pending <= expected_rows.size();
    fail_count   <= mismatch_count;
  end

endmodule

[tb/tb_glyph_blit_clipped_top.sv]
`timescale 1ns / 100ps

module tb_glyph_blit_clipped_top;
  import gbc_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASES         = 8;
  localparam int PHASE_REQUESTS = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rows_taken = 1'b0;
  int   fail_count;
  int   rows_pending;
  int   cycle_count = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   requests_sent = 0;
  // effective geometry, used only to shape stimulus
  int   eff_cell_w = 8;
  int   eff_cell_h = 8;
  int   cur_first = 32;
  int   cur_fb_w = 320;
  int   cur_fb_h = 240;
  bit   bitmap_loaded [BITMAP_DEPTH];
  bit   width_loaded [GLYPH_COUNT];

  gbc_item_if   item_ch ();
  gbc_result_if row_ch ();
  gbc_cfg_if    cfg_ch ();

  assign row_ch.ready = rows_taken;

  glyph_blit_clipped_top dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (row_ch),
    .cfg     (cfg_ch)
  );

  gbc_blit_checker row_checker (
    .clk          (clk),
    .rst          (rst),
    .items        (item_ch),
    .results      (row_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    rows_taken <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("glyph_blit_clipped_top verification failed");
      $finish;
    end
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int pick_extent();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1023;
      2, 3, 4: return $urandom_range(40, 1);
      default: return $urandom_range(1023, 1);
    endcase
  endfunction

  // Positions cluster around the framebuffer edges so clipping is hit often.
  function automatic int pick_position(input int extent, input int size);
    int pos;
    case ($urandom_range(4))
      0:       pos = int'($urandom_range(2047)) - 1024;
      1:       pos = -int'($urandom_range(size));
      2:       pos = extent - int'($urandom_range(size));
      default: pos = (extent > 0) ? int'($urandom_range(extent - 1)) : 0;
    endcase
    return (pos > 1023) ? 1023 : pos;
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [7:0] code,
                           input int px, input int py, input logic [11:0] idx,
                           input logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.opcode      <= op;
    item_ch.char_code   <= code;
    item_ch.pos_x       <= 11'(px);
    item_ch.pos_y       <= 11'(py);
    item_ch.table_index <= idx;
    item_ch.table_data  <= data;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic load_byte(input logic [11:0] idx, input logic [7:0] data);
    send_item(OP_LOAD_BITMAP, 8'($urandom), int'($urandom_range(2047)) - 1024,
              int'($urandom_range(2047)) - 1024, idx, data);
    bitmap_loaded[idx] = 1'b1;
  endtask

  task automatic load_width(input logic [11:0] idx, input logic [7:0] data);
    send_item(OP_LOAD_WIDTH, 8'($urandom), int'($urandom_range(2047)) - 1024,
              int'($urandom_range(2047)) - 1024, idx, data);
    if (idx < GLYPH_COUNT) width_loaded[idx[GIDX_W-1:0]] = 1'b1;
  endtask

  // Fill in whatever the current geometry needs of this glyph that is still unloaded.
  task automatic prepare_glyph(input int gi);
    int stride, first_byte;
    stride     = (eff_cell_w + 7) / 8;
    first_byte = stride * eff_cell_h * gi;
    for (int b = 0; b < stride * eff_cell_h; b++) begin
      if (!bitmap_loaded[(first_byte + b) % BITMAP_DEPTH])
        load_byte(12'((first_byte + b) % BITMAP_DEPTH), 8'($urandom));
    end
    if (!width_loaded[gi]) load_width(12'(gi), 8'($urandom));
  endtask

  task automatic draw_char(input logic [7:0] code, input int px, input int py);
    int gi;
    gi = int'(code) - cur_first;
    // characters outside the font still address glyph 0
    prepare_glyph((gi >= 0 && gi < GLYPH_COUNT) ? gi : 0);
    send_item(OP_DRAW, code, px, py, 12'($urandom), 8'($urandom));
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value, input int bits);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'(value);
    if (bits < CFG_DATA_W && $urandom_range(1) == 1)
      word = word | (CFG_DATA_W'($urandom) << bits);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= word;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Drop the request line and let the block drain completely.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target, pick, code;
    int fg, bg, md, fbw, fbh, cw, ch, first;
    item_ch.valid       <= 1'b0;
    item_ch.opcode      <= OP_DRAW;
    item_ch.char_code   <= '0;
    item_ch.pos_x       <= '0;
    item_ch.pos_y       <= '0;
    item_ch.table_index <= '0;
    item_ch.table_data  <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_FG_COLOUR;
    cfg_ch.data         <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: clipping on every side, off-font codes, unused opcode
    draw_char(8'(cur_first), 0, 0);
    draw_char(8'(cur_first), -3, -2);
    draw_char(8'(cur_first), 316, 236);
    draw_char(8'(cur_first), -8, 0);
    draw_char(8'(cur_first), -1024, -1024);
    draw_char(8'(cur_first), 1023, 1023);
    draw_char(8'(cur_first - 1), 10, 10);
    draw_char(8'hFF, 10, 10);
    send_item(OP_UNUSED, 8'hFF, -1, -1, 12'hFFF, 8'hFF);
    load_width(12'hFFF, 8'hFF);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
        default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
      endcase
      if (p == 0) begin
        fg = 0; bg = 16'hFFFF; md = 0; fbw = 1; fbh = 1; cw = 0; ch = 0; first = 0;
      end else if (p == 1) begin
        fg = 16'hFFFF; bg = 0; md = 7; fbw = 1023; fbh = 1023; cw = 31; ch = 31; first = 255;
      end else begin
        fg    = $urandom_range(16'hFFFF);
        bg    = $urandom_range(16'hFFFF);
        md    = $urandom_range(7);
        fbw   = pick_extent();
        fbh   = pick_extent();
        cw    = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(10, 1);
        ch    = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6, 1);
        first = ($urandom_range(2) == 0) ? $urandom_range(255) : $urandom_range(64);
      end
      write_reg(REG_FG_COLOUR, fg, 16);
      write_reg(REG_BG_COLOUR, bg, 16);
      write_reg(REG_MODE, md, 3);
      write_reg(REG_FB_WIDTH, fbw, 10);
      write_reg(REG_FB_HEIGHT, fbh, 10);
      write_reg(REG_CELL_WIDTH, cw, 5);
      write_reg(REG_CELL_HEIGHT, ch, 5);
      write_reg(REG_FIRST_CHAR, first, 8);
      cfg_ch.valid <= 1'b0;
      @(posedge clk);
      eff_cell_w = clamp_int(cw, 1, MAX_CELL_WIDTH);
      eff_cell_h = clamp_int(ch, 1, MAX_CELL_HEIGHT);
      cur_first  = first;
      cur_fb_w   = fbw;
      cur_fb_h   = fbh;

      target = requests_sent + PHASE_REQUESTS;
      while (requests_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 64) begin
          case ($urandom_range(9))
            0:       code = $urandom_range(255);
            1:       code = cur_first + GLYPH_COUNT - 1 - $urandom_range(3);
            default: code = cur_first + $urandom_range(5);
          endcase
          draw_char(8'(code % 256), pick_position(cur_fb_w, eff_cell_w),
                    pick_position(cur_fb_h, eff_cell_h));
        end else if (pick < 74) begin
          load_byte(12'($urandom), 8'($urandom));
        end else if (pick < 86) begin
          load_width(($urandom_range(1) == 1) ? 12'($urandom_range(GLYPH_COUNT - 1))
                                              : 12'($urandom), 8'($urandom));
        end else if (pick < 95) begin
          send_item(OP_UNUSED, 8'($urandom), int'($urandom_range(2047)) - 1024,
                    int'($urandom_range(2047)) - 1024, 12'($urandom), 8'($urandom));
        end else begin
          wait_idle();
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("glyph_blit_clipped_top verification clean");
    end else begin
      $display("glyph_blit_clipped_top verification failed");
    end
    $finish;
  end

endmodule
